### design/hbd_pkg.sv
// Shared types, codes and the hex digit decoder for the HTTP body dechunker.
// Used by hbd_chunk_parser and http_body_dechunker_core; depends on nothing.
package hbd_pkg;

   localparam int BYTE_BITS = 8;
   localparam int MODE_BITS = 2;
   localparam int REG_BITS  = 32;
   localparam int SKIP_BITS = 2;

   localparam logic [MODE_BITS-1:0] MODE_RAW     = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_LENGTH  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_CHUNKED = 2'd2;

   localparam logic CSR_BODY_MODE      = 1'b0;
   localparam logic CSR_CONTENT_LENGTH = 1'b1;

   localparam logic [BYTE_BITS-1:0] CHAR_CR = 8'h0D;
   localparam logic [BYTE_BITS-1:0] CHAR_LF = 8'h0A;

   localparam logic [SKIP_BITS-1:0] SKIP_AFTER_DATA = 2'd2;

   typedef enum logic [2:0] {
      PH_DIGITS = 3'd0,
      PH_TEXT   = 3'd1,
      PH_CR     = 3'd2,
      PH_DATA   = 3'd3,
      PH_SKIP   = 3'd4
   } phase_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   typedef struct packed {
      logic pass;
      logic done;
      logic error;
   } chunk_result_type;

   function automatic hex_type hex_decode(input logic [BYTE_BITS-1:0] b);
      hex_type h;
      h.ok    = 1'b1;
      h.value = 4'd0;
      case (b) inside
         [8'h30:8'h39]: h.value = 4'(b - 8'h30);
         [8'h41:8'h46]: h.value = 4'(b - 8'h41 + 8'd10);
         [8'h61:8'h66]: h.value = 4'(b - 8'h61 + 8'd10);
         default:       h.ok    = 1'b0;
      endcase
      return h;
   endfunction

endpackage

### design/hbd_chunk_parser.sv
// Chunk size line parser and chunk data counter for chunked transfer encoding.
// Depends on hbd_pkg; instantiated by http_body_dechunker_core.
module hbd_chunk_parser #(
   parameter int LEN_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [hbd_pkg::BYTE_BITS-1:0] in_byte,
   output hbd_pkg::chunk_result_type     result
);
   import hbd_pkg::*;

   phase_type             phase_ff, phase_in;
   logic [LEN_BITS-1:0]   remaining_ff, remaining_in;
   logic                  digit_seen_ff, digit_seen_in;
   logic [SKIP_BITS-1:0]  skip_ff, skip_in;
   logic                  error_ff, error_in;
   logic [LEN_BITS-1:0]   remaining_dec;
   hex_type               hex;

   assign hex           = hex_decode(in_byte);
   assign remaining_dec = remaining_ff - LEN_BITS'(1);

   always_comb begin
      phase_in      = phase_ff;
      remaining_in  = remaining_ff;
      digit_seen_in = digit_seen_ff;
      skip_in       = skip_ff;
      error_in      = error_ff;
      result.pass   = 1'b0;
      result.done   = 1'b0;
      if (step && !error_ff) begin
         unique case (phase_ff)
            PH_DIGITS: begin
               if (hex.ok) begin
                  if (remaining_ff[LEN_BITS-1 -: 4] != 4'd0) begin
                     error_in = 1'b1;
                  end else begin
                     remaining_in  = {remaining_ff[LEN_BITS-5:0], hex.value};
                     digit_seen_in = 1'b1;
                  end
               end else if (in_byte == CHAR_CR) begin
                  phase_in = PH_CR;
               end else begin
                  phase_in = PH_TEXT;
               end
            end
            PH_TEXT: begin
               if (in_byte == CHAR_CR) begin
                  phase_in = PH_CR;
               end
            end
            PH_CR: begin
               if (in_byte == CHAR_LF) begin
                  if (!digit_seen_ff) begin
                     error_in = 1'b1;
                  end else if (remaining_ff == '0) begin
                     result.done = 1'b1;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end else if (in_byte != CHAR_CR) begin
                  phase_in = PH_TEXT;
               end
            end
            PH_DATA: begin
               result.pass  = 1'b1;
               remaining_in = remaining_dec;
               if (remaining_dec == '0) begin
                  phase_in = PH_SKIP;
                  skip_in  = SKIP_AFTER_DATA;
               end
            end
            PH_SKIP: begin
               if (skip_ff != '0) begin
                  skip_in = skip_ff - SKIP_BITS'(1);
               end
               if (skip_ff <= SKIP_BITS'(1)) begin
                  phase_in      = PH_DIGITS;
                  remaining_in  = '0;
                  digit_seen_in = 1'b0;
                  skip_in       = '0;
               end
            end
            default: begin
               phase_in      = PH_DIGITS;
               remaining_in  = '0;
               digit_seen_in = 1'b0;
               skip_in       = '0;
            end
         endcase
      end
      result.error = error_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_DIGITS;
         remaining_ff  <= '0;
         digit_seen_ff <= 1'b0;
         skip_ff       <= '0;
         error_ff      <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         remaining_ff  <= remaining_in;
         digit_seen_ff <= digit_seen_in;
         skip_ff       <= skip_in;
         error_ff      <= error_in;
      end
   end

endmodule

### design/http_body_dechunker_core.sv
// HTTP body dechunker top level: mode and length registers, byte counter and
// result register. Depends on hbd_pkg and hbd_chunk_parser.
// The result word is registered and appears in the cycle after its word is accepted.
// Throughput is one word per cycle; the result register stalls input only
// while its word is held by rsp_tready low.
// Synchronous reset clears parser, counters, flags and length; mode is raw.
module http_body_dechunker_core #(
   parameter int LEN_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] body_byte
   output logic [2:0]  rsp_tuser    // [0] body_valid, [1] body_done, [2] size_error
);
   import hbd_pkg::*;

   logic [MODE_BITS-1:0] mode_ff;
   logic [REG_BITS-1:0]  length_ff;
   logic [REG_BITS-1:0]  received_ff, received_in;
   logic [REG_BITS-1:0]  received_inc;
   logic                 finished_ff, finished_in;
   logic                 accept;
   logic                 chunk_step;
   logic                 pass;
   chunk_result_type     chunk_result;
   logic                 rsp_valid_ff;
   logic [7:0]           rsp_data_ff;
   logic [2:0]           rsp_user_ff;

   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign accept       = req_tvalid && req_tready;
   assign received_inc = received_ff + REG_BITS'(1);

   hbd_chunk_parser #(
      .LEN_BITS(LEN_BITS)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (chunk_step),
      .in_byte (req_tdata),
      .result  (chunk_result)
   );

   always_comb begin
      pass        = 1'b0;
      chunk_step  = 1'b0;
      finished_in = finished_ff;
      received_in = received_ff;
      if (accept && !finished_ff) begin
         unique case (mode_ff)
            MODE_LENGTH: begin
               if (received_ff >= length_ff) begin
                  finished_in = 1'b1;
               end else begin
                  pass        = 1'b1;
                  received_in = received_inc;
                  if (received_inc >= length_ff) begin
                     finished_in = 1'b1;
                  end
               end
            end
            MODE_CHUNKED: begin
               chunk_step = 1'b1;
               pass       = chunk_result.pass;
               if (chunk_result.done) begin
                  finished_in = 1'b1;
               end
            end
            default: begin
               pass = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_RAW;
         length_ff   <= '0;
         received_ff <= '0;
         finished_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_BODY_MODE:      mode_ff   <= csr_wdata[MODE_BITS-1:0];
               CSR_CONTENT_LENGTH: length_ff <= csr_wdata;
               default:            mode_ff   <= mode_ff;
            endcase
         end
         received_ff <= received_in;
         finished_ff <= finished_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= pass ? req_tdata : 8'd0;
         rsp_user_ff <= {chunk_result.error, finished_in, pass};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

### tb/sv/tb_http_body_dechunker_core.sv
// Self-checking testbench for http_body_dechunker_core: drives body bytes in raw, length
// and chunked modes and checks every result word against a bit-accurate predictor.
// Depends on hbd_pkg and the design sources only.
`timescale 1ns / 1ps

import hbd_pkg::*;

typedef struct packed {
   logic       valid;
   logic [7:0] data;
   logic       done;
   logic       error;
} dechunked_word_type;

localparam logic [7:0] CHAR_ZERO    = 8'h30;
localparam logic [7:0] CHAR_NINE    = 8'h39;
localparam logic [7:0] CHAR_UPPER_A = 8'h41;
localparam logic [7:0] CHAR_UPPER_F = 8'h46;
localparam logic [7:0] CHAR_LOWER_A = 8'h61;
localparam logic [7:0] CHAR_LOWER_F = 8'h66;
localparam logic [7:0] CHAR_SEMI    = 8'h3B;

localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;

class dechunk_scoreboard;
   logic [1:0]         mode;
   logic [31:0]        content_len;
   phase_type          phase;
   logic [31:0]        remaining;
   logic               digit_seen;
   logic [1:0]         skip_left;
   logic [31:0]        length_count;
   logic               finished;
   logic               size_err;
   dechunked_word_type expected_words[$];
   int                 mismatches;

   function new();
      mode         = MODE_RAW;
      content_len  = '0;
      length_count = '0;
      finished     = 1'b0;
      size_err     = 1'b0;
      mismatches   = 0;
      restart_line();
   endfunction

   function void restart_line();
      phase      = PH_DIGITS;
      remaining  = '0;
      digit_seen = 1'b0;
      skip_left  = '0;
   endfunction

   function void write_reg(logic index, logic [31:0] value);
      if (index == CSR_BODY_MODE) mode = value[1:0];
      else content_len = value;
   endfunction

   function bit hex_nibble(input logic [7:0] b, output logic [3:0] v);
      v = 4'd0;
      if (b >= CHAR_ZERO && b <= CHAR_NINE) v = 4'(b - CHAR_ZERO);
      else if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_F) v = 4'(b - CHAR_UPPER_A + 8'd10);
      else if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_F) v = 4'(b - CHAR_LOWER_A + 8'd10);
      else return 1'b0;
      return 1'b1;
   endfunction

   function logic chunk_step(logic [7:0] b);
      logic [3:0] v;
      if (size_err) return 1'b0;
      case (phase)
         PH_DIGITS: begin
            if (hex_nibble(b, v)) begin
               if (remaining[31:28] != 4'd0) begin
                  size_err = 1'b1;
               end else begin
                  remaining  = {remaining[27:0], v};
                  digit_seen = 1'b1;
               end
            end else if (b == CHAR_CR) begin
               phase = PH_CR;
            end else begin
               phase = PH_TEXT;
            end
            return 1'b0;
         end
         PH_TEXT: begin
            if (b == CHAR_CR) phase = PH_CR;
            return 1'b0;
         end
         PH_CR: begin
            if (b == CHAR_LF) begin
               if (!digit_seen) size_err = 1'b1;
               else if (remaining == '0) finished = 1'b1;
               else phase = PH_DATA;
            end else if (b != CHAR_CR) begin
               phase = PH_TEXT;
            end
            return 1'b0;
         end
         PH_DATA: begin
            remaining = remaining - 32'd1;
            if (remaining == '0) begin
               phase     = PH_SKIP;
               skip_left = SKIP_AFTER_DATA;
            end
            return 1'b1;
         end
         PH_SKIP: begin
            if (skip_left != '0) skip_left = skip_left - 2'd1;
            if (skip_left == '0) restart_line();
            return 1'b0;
         end
         default: begin
            restart_line();
            return 1'b0;
         end
      endcase
   endfunction

   function void note_byte(logic [7:0] b);
      dechunked_word_type w;
      logic               pass;
      pass = 1'b0;
      if (!finished) begin
         case (mode)
            MODE_LENGTH: begin
               if (length_count >= content_len) begin
                  finished = 1'b1;
               end else begin
                  pass         = 1'b1;
                  length_count = length_count + 32'd1;
                  if (length_count >= content_len) finished = 1'b1;
               end
            end
            MODE_CHUNKED: pass = chunk_step(b);
            default:      pass = 1'b1;
         endcase
      end
      w.valid = pass;
      w.data  = pass ? b : 8'h00;
      w.done  = finished;
      w.error = size_err;
      expected_words.push_back(w);
   endfunction

   task report_mismatch(string what);
      mismatches++;
      $display("MISMATCH at %0t: %s", $time, what);
   endtask

   task check_word(logic [7:0] data, logic [2:0] user);
      dechunked_word_type w;
      if (expected_words.size() == 0) begin
         report_mismatch($sformatf("result word with nothing predicted, data %02h", data));
         return;
      end
      w = expected_words.pop_front();
      if (user[0] !== w.valid)
         report_mismatch($sformatf("body_valid %b, predicted %b", user[0], w.valid));
      if (data !== w.data)
         report_mismatch($sformatf("body_byte %02h, predicted %02h", data, w.data));
      if (user[1] !== w.done)
         report_mismatch($sformatf("body_done %b, predicted %b", user[1], w.done));
      if (user[2] !== w.error)
         report_mismatch($sformatf("size_error %b, predicted %b", user[2], w.error));
   endtask
endclass

module tb_http_body_dechunker_core;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic        csr_index;
   logic [31:0] csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] in_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [7:0] body_byte
   logic [2:0]  rsp_tuser;   // [0] body_valid, [1] body_done, [2] size_error

   dechunk_scoreboard sb;
   bit quiet;
   int rx_hold;
   int words_sent;
   int cycle_count;

   http_body_dechunker_core dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   function automatic bit take_break();
      return !quiet && $urandom_range(0, 99) < 36;
   endfunction

   always @(negedge clock) begin
      if (rx_hold > 0) begin
         rsp_tready <= 1'b0;
         rx_hold = rx_hold - 1;
      end else begin
         rsp_tready <= !take_break();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata, rsp_tuser);
   end

   task automatic send_byte(input logic [7:0] value);
      @(negedge clock);
      while (take_break()) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      sb.note_byte(value);
      words_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic end_line();
      send_byte(CHAR_CR);
      send_byte(CHAR_LF);
   endtask

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++) send_byte(8'($urandom_range(0, 255)));
   endtask

   function automatic logic [7:0] text_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == CHAR_CR);
      return b;
   endfunction

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.expected_words.size() != 0) @(negedge clock);
   endtask

   task automatic set_reg(input logic index, input logic [31:0] value);
      wait_drained();
      repeat (2) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      sb.write_reg(index, value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_size_line(input int unsigned size);
      logic [3:0]  nib;
      logic [7:0]  ch;
      logic [7:0]  junk;
      bit          started;
      int          variant;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) send_byte(CHAR_ZERO);
      started = (size == 0);
      if (size == 0) send_byte(CHAR_ZERO);
      for (int i = 7; i >= 0; i--) begin
         nib = 4'(size >> (4 * i));
         if (nib != 4'd0) started = 1'b1;
         if (started && size != 0) begin
            if (nib < 4'd10) ch = CHAR_ZERO + 8'(nib);
            else if ($urandom_range(0, 1)) ch = CHAR_UPPER_A + 8'(nib - 4'd10);
            else ch = CHAR_LOWER_A + 8'(nib - 4'd10);
            send_byte(ch);
         end
      end
      variant = $urandom_range(0, 9);
      if (variant < 2) begin
         send_byte(CHAR_SEMI);
         repeat ($urandom_range(0, 6)) send_byte(text_byte());
      end else if (variant == 2) begin
         send_byte(CHAR_CR);
         do junk = 8'($urandom_range(0, 255)); while (junk == CHAR_CR || junk == CHAR_LF);
         send_byte(junk);
         repeat ($urandom_range(0, 3)) send_byte(text_byte());
      end else if (variant == 3) begin
         send_byte(CHAR_CR);
      end
      end_line();
   endtask

   task automatic detour();
      int count;
      int pick;
      count = $urandom_range(1, 12);
      pick  = $urandom_range(0, 2);
      if (pick == 0) begin
         if ($urandom_range(0, 2) == 0) set_reg(CSR_CONTENT_LENGTH, 32'd0);
         set_reg(CSR_BODY_MODE, 32'(MODE_RAW));
      end else if (pick == 1) begin
         if ($urandom_range(0, 1)) set_reg(CSR_CONTENT_LENGTH, 32'hFFFF_FFFF);
         else set_reg(CSR_CONTENT_LENGTH, sb.length_count + count + $urandom_range(1, 500));
         set_reg(CSR_BODY_MODE, 32'(MODE_LENGTH));
      end else begin
         set_reg(CSR_BODY_MODE, 32'(MODE_SPARE));
      end
      send_random(count);
      set_reg(CSR_BODY_MODE, 32'(MODE_CHUNKED));
   endtask

   task automatic send_chunk(input int unsigned size);
      int unsigned split;
      split = 0;
      if (size >= 2 && $urandom_range(0, 7) == 0) split = $urandom_range(1, size - 1);
      send_size_line(size);
      for (int unsigned i = 0; i < size; i++) begin
         if (split != 0 && i == split) detour();
         send_byte(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 3) == 0) send_random(2);
      else end_line();
   endtask

   function automatic int unsigned pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return $urandom_range(1, 16);
      if (r < 97) return $urandom_range(17, 64);
      return $urandom_range(65, 300);
   endfunction

   initial begin
      int  ending;
      int  quiet_until;
      bit  quiet_done;
      bit  stall_done;
      bit  pause_done;
      sb          = new();
      quiet       = 1'b0;
      quiet_done  = 1'b0;
      stall_done  = 1'b0;
      pause_done  = 1'b0;
      quiet_until = 0;
      rx_hold     = 0;
      words_sent  = 0;
      reset       = 1'b1;
      csr_we      = 1'b0;
      csr_index   = CSR_BODY_MODE;
      csr_wdata   = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Raw mode after reset, the spare mode code and an open-ended length.
      send_byte(8'h00);
      send_byte(8'hFF);
      set_reg(CSR_BODY_MODE, 32'(MODE_SPARE));
      send_byte(CHAR_CR);
      send_byte(CHAR_LF);
      set_reg(CSR_CONTENT_LENGTH, 32'hFFFF_FFFF);
      set_reg(CSR_BODY_MODE, 32'(MODE_LENGTH));
      send_byte(8'h5A);

      // Chunked: extension holding a hex digit, a doubled CR, and a CR broken by text.
      set_reg(CSR_BODY_MODE, 32'(MODE_CHUNKED));
      send_text("1;7");
      send_byte(CHAR_CR);
      end_line();
      send_byte(8'hFF);
      end_line();
      send_text("2");
      send_byte(CHAR_CR);
      send_text("Z3");
      end_line();
      send_byte(8'h00);
      send_byte(8'h80);
      send_text("xy");

      while (words_sent < 1850) begin
         if (!quiet_done && words_sent > 400) begin
            quiet       = 1'b1;
            quiet_done  = 1'b1;
            quiet_until = words_sent + 250;
         end
         if (quiet && words_sent > quiet_until) quiet = 1'b0;
         if (!stall_done && words_sent > 900) begin
            stall_done = 1'b1;
            rx_hold    = 300;
         end
         if (!pause_done && words_sent > 1300) begin
            pause_done = 1'b1;
            wait_drained();
         end
         if ($urandom_range(0, 99) < 10) detour();
         else send_chunk(pick_size());
      end

      ending = $urandom_range(0, 2);
      if (ending == 0) begin
         // A zero-size chunk ends the body; everything after it is dropped.
         send_size_line(0);
         send_random(5);
         set_reg(CSR_BODY_MODE, 32'(MODE_RAW));
         send_random(3);
         set_reg(CSR_BODY_MODE, 32'(MODE_LENGTH));
         send_random(3);
      end else begin
         if (ending == 1) send_text("123456789");
         else begin
            send_text(";ext");
            end_line();
         end
         send_text("3");
         end_line();
         send_random(5);
         set_reg(CSR_BODY_MODE, 32'(MODE_RAW));
         send_random(4);
         if (ending == 1) set_reg(CSR_CONTENT_LENGTH, sb.length_count + 32'd3);
         else set_reg(CSR_CONTENT_LENGTH, 32'd0);
         set_reg(CSR_BODY_MODE, 32'(MODE_LENGTH));
         send_random(6);
         set_reg(CSR_BODY_MODE, 32'(MODE_SPARE));
         send_random(2);
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (sb.expected_words.size() != 0)
         sb.report_mismatch($sformatf("%0d predicted words never arrived",
                                      sb.expected_words.size()));
      if (sb.mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### sim.f
design/hbd_pkg.sv
design/hbd_chunk_parser.sv
design/http_body_dechunker_core.sv
tb/sv/tb_http_body_dechunker_core.sv
